// ----- src/sseg_pkg.sv -----
// Shared types, codes and glyph tables for the seven-segment display driver.
`timescale 1ns / 1ps

package sseg_pkg;

  localparam int STORE_DEPTH = 3;
  localparam int GLYPH_W     = 7;
  localparam logic [7:0] GLYPH_BASE = 8'd48;
  localparam logic [7:0] GLYPH_END  = 8'd88;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_NUMBER = 2'd1,
    FUNC_TEXT   = 2'd2
  } func_t;

  typedef logic [GLYPH_W-1:0] glyph_t;
  typedef glyph_t [STORE_DEPTH-1:0] digits_t;

  // One scan result: active-low digit enables and the segment pattern.
  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] enable_n;
  } result_t;

  // Glyph table indexed by character code minus '0'.
  function automatic logic [7:0] glyph_lookup(input logic [5:0] idx);
    logic [7:0] g;
    case (idx)
      6'd0:  g = 8'h5F;
      6'd1:  g = 8'h44;
      6'd2:  g = 8'h3D;
      6'd3:  g = 8'h75;
      6'd4:  g = 8'h66;
      6'd5:  g = 8'h73;
      6'd6:  g = 8'h7B;
      6'd7:  g = 8'h45;
      6'd8:  g = 8'h7F;
      6'd9:  g = 8'h77;
      6'd17: g = 8'h6F;
      6'd18: g = 8'h7A;
      6'd19: g = 8'h1B;
      6'd20: g = 8'h7C;
      6'd21: g = 8'h3B;
      6'd22: g = 8'h2B;
      6'd23: g = 8'h5B;
      6'd24: g = 8'h6E;
      6'd25: g = 8'h0A;
      6'd28: g = 8'h1A;
      6'd30: g = 8'h68;
      6'd31: g = 8'h5F;
      6'd32: g = 8'h2F;
      6'd34: g = 8'h28;
      6'd35: g = 8'h73;
      6'd36: g = 8'h3A;
      6'd37: g = 8'h1E;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // Character to glyph; anything outside the table shows blank.
  function automatic glyph_t char_glyph(input logic [7:0] c);
    logic [7:0] g;
    logic [7:0] off;
    off = c - GLYPH_BASE;
    g = 8'h00;
    if (c >= GLYPH_BASE && c < GLYPH_END) begin
      g = glyph_lookup(off[5:0]);
    end
    return g[GLYPH_W-1:0];
  endfunction

  // Decimal digit to glyph.
  function automatic glyph_t digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    g = glyph_lookup({2'b00, d});
    return g[GLYPH_W-1:0];
  endfunction

endpackage

// ----- src/seven_segment_mux_driver.sv -----
// Top level of the multiplexed seven-segment display driver.
`timescale 1ns / 1ps
//
// Usage: items arrive on the s_ stream. s_tuser selects the function: tick,
// load number or load text. A load-number transfer turns s_tdata[7:0] into
// decimal glyphs; a load-text transfer maps up to three characters into the
// digit store, the last character in digit zero. Loads produce no output.
// Each tick transfer produces one m_ transfer carrying the active-low enable
// of the current digit and its segments, then the scan moves to the next
// digit and wraps after DIGIT_COUNT digits. In number mode the upper digits
// are blank for values below 10 and 100. The decimal point follows the
// dot_on register, written through the cfg channel, and shows on digit zero.
// One item is taken per cycle while the result queue has room; a tick result
// appears on m_tvalid in the cycle after its transfer when no earlier result
// is still waiting. A two-entry result queue lets the block keep taking items
// while the receiver stalls; s_tready drops only when both queue entries are
// held. Reset clears the digit store to blank, the number to zero, the scan to
// digit zero and dot_on to zero.
//

module seven_segment_mux_driver import sseg_pkg::*; #(
  parameter int DIGIT_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata fields from bit 0: number_value[7:0], char_first[15:8],
  // char_second[23:16], char_third[31:24], text_length[33:32], zero pad.
  input  logic [39:0] s_tdata,
  // s_tuser fields from bit 0: func[1:0].
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata fields from bit 0: digit_enable_n[2:0], segments[10:3], zero pad.
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int UsedDigits = (DIGIT_COUNT < 1) ? 1 :
                              (DIGIT_COUNT > STORE_DEPTH) ? STORE_DEPTH : DIGIT_COUNT;
  localparam logic [1:0] LastPos = 2'(UsedDigits - 1);

  digits_t    digit_store;
  logic       at_least_10;
  logic       at_least_100;
  logic [1:0] scan_pos;
  logic       dot_on;

  digits_t    number_glyphs;
  digits_t    text_glyphs;
  func_t      func;
  logic       accept;
  logic       queue_full;
  logic [1:0] pos;
  result_t    tick_result;
  result_t    out_data;

  assign func      = func_t'(s_tuser);
  assign s_tready  = !queue_full;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  sseg_digits #(
    .USED_DIGITS(UsedDigits)
  ) u_digits (
    .number_value (s_tdata[7:0]),
    .char_first   (s_tdata[15:8]),
    .char_second  (s_tdata[23:16]),
    .char_third   (s_tdata[31:24]),
    .text_length  (s_tdata[33:32]),
    .number_glyphs(number_glyphs),
    .text_glyphs  (text_glyphs)
  );

  // Segment pattern for the digit under the scan.
  always_comb begin
    pos = (scan_pos > LastPos) ? 2'd0 : scan_pos;
    tick_result.enable_n = ~(3'b001 << pos);
    case (pos)
      2'd0:    tick_result.segments = {dot_on, digit_store[0]};
      2'd1:    tick_result.segments = at_least_10 ? {1'b0, digit_store[1]} : 8'h00;
      2'd2:    tick_result.segments = at_least_100 ? {1'b0, digit_store[2]} : 8'h00;
      default: tick_result.segments = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_on <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      dot_on <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_store  <= '0;
      at_least_10  <= 1'b0;
      at_least_100 <= 1'b0;
      scan_pos     <= 2'd0;
    end else if (accept) begin
      case (func)
        FUNC_TICK: begin
          scan_pos <= (pos == LastPos) ? 2'd0 : pos + 2'd1;
        end
        FUNC_NUMBER: begin
          // Only the digits in use are refreshed by a number load.
          for (int i = 0; i < UsedDigits; i++) begin
            digit_store[i] <= number_glyphs[i];
          end
          at_least_10  <= (s_tdata[7:0] >= 8'd10);
          at_least_100 <= (s_tdata[7:0] >= 8'd100);
        end
        FUNC_TEXT: begin
          // Text mode shows every digit, blank ones included.
          digit_store  <= text_glyphs;
          at_least_10  <= 1'b1;
          at_least_100 <= 1'b1;
        end
        default: begin
          scan_pos <= scan_pos;
        end
      endcase
    end
  end

  sseg_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && func == FUNC_TICK),
    .push_data(tick_result),
    .full     (queue_full),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_data)
  );

  assign m_tdata = {5'b00000, out_data.segments, out_data.enable_n};

  // A tick taken while the output is empty shows up in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_TICK && !m_tvalid) |=> m_tvalid)
    else $error("tick result missing after transfer");

  // Exactly one digit is enabled in every result.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(~m_tdata[2:0]))
    else $error("result enables other than one digit");

  // The decimal point only ever appears together with digit zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[10]) |-> !m_tdata[0])
    else $error("decimal point on a digit other than zero");

  // The scan never leaves the digits in use.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (scan_pos <= LastPos))
    else $error("scan position out of range");

endmodule

// ----- src/sseg_digits.sv -----
// Converts a loaded byte or a loaded text into glyphs for the digit store.
`timescale 1ns / 1ps

module sseg_digits import sseg_pkg::*; #(
  parameter int USED_DIGITS = 3
) (
  input  logic [7:0] number_value,
  input  logic [7:0] char_first,
  input  logic [7:0] char_second,
  input  logic [7:0] char_third,
  input  logic [1:0] text_length,
  output digits_t    number_glyphs,
  output digits_t    text_glyphs
);

  logic [1:0]  hundreds;
  logic [6:0]  rest;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  ones;
  logic [1:0]  size;

  // Hundreds by compare, tens by multiplying with 205/2048 (exact below 100).
  always_comb begin
    if (number_value >= 8'd200) begin
      hundreds = 2'd2;
      rest     = 7'(number_value - 8'd200);
    end else if (number_value >= 8'd100) begin
      hundreds = 2'd1;
      rest     = 7'(number_value - 8'd100);
    end else begin
      hundreds = 2'd0;
      rest     = number_value[6:0];
    end
    tens_prod = 15'(rest) * 15'd205;
    tens      = tens_prod[14:11];
    tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    ones      = rest - tens_x10;
  end

  assign number_glyphs[0] = digit_glyph(ones[3:0]);
  assign number_glyphs[1] = digit_glyph(tens);
  assign number_glyphs[2] = digit_glyph({2'b00, hundreds});

  // The last character of the text lands in digit zero.
  assign size = (text_length > 2'(USED_DIGITS)) ? 2'(USED_DIGITS) : text_length;

  always_comb begin
    text_glyphs = '0;
    case (size)
      2'd1: begin
        text_glyphs[0] = char_glyph(char_first);
      end
      2'd2: begin
        text_glyphs[1] = char_glyph(char_first);
        text_glyphs[0] = char_glyph(char_second);
      end
      2'd3: begin
        text_glyphs[2] = char_glyph(char_first);
        text_glyphs[1] = char_glyph(char_second);
        text_glyphs[0] = char_glyph(char_third);
      end
      default: begin
        text_glyphs = '0;
      end
    endcase
  end

endmodule

// ----- src/sseg_out_queue.sv -----
// Two-entry result queue that separates the scan logic from the output stream.
`timescale 1ns / 1ps

module sseg_out_queue import sseg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    slot0;
  result_t    slot1;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
        slot1 <= push_data;
      end else begin
        slot0 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

// ----- sim/tb_seven_segment_mux_driver.sv -----
// Self-checking testbench for the multiplexed seven-segment display driver.
`timescale 1ns / 1ps

module tb_seven_segment_mux_driver import sseg_pkg::*;;

  localparam int DIGITS       = 3;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 4;     // settle time before a register write and at the end
  localparam int HOLD_CYCLES  = 80;    // long receiver stall that backs up the block
  localparam int PLAN_ROWS    = 25;

  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [15:0] TEXT_MARK   = 16'hFFFF;
  localparam logic [7:0]  CHAR_ZERO   = 8'd48;
  localparam logic [7:0]  CHAR_LAST   = 8'd87;

  // Segment patterns for the characters starting at '0', in character order.
  localparam logic [0:39][7:0] GLYPH_ROM = {
    8'h5F, 8'h44, 8'h3D, 8'h75, 8'h66, 8'h73, 8'h7B, 8'h45, 8'h7F, 8'h77,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6F, 8'h7A, 8'h1B,
    8'h7C, 8'h3B, 8'h2B, 8'h5B, 8'h6E, 8'h0A, 8'h00, 8'h00, 8'h1A, 8'h00,
    8'h68, 8'h5F, 8'h2F, 8'h00, 8'h28, 8'h73, 8'h3A, 8'h1E, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [1:0]  func;
    logic [39:0] data;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  // Mirror of the display state, updated on every accepted input transfer.
  logic [2:0][6:0] shadow_digits;
  logic [15:0]     shadow_number;
  logic [1:0]      shadow_scan;
  logic            shadow_dot;

  result_t   pending_scans[$];
  plan_row_t plan[PLAN_ROWS];
  int        error_count = 0;
  int        idle_cycles = 0;
  int        src_idle_pct = 0;
  int        sink_idle_pct = 0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  result_t   got_scan;
  result_t   want_scan;

  seven_segment_mux_driver #(
    .DIGIT_COUNT(DIGITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [39:0] pack_item(input logic [7:0] num, input logic [7:0] c1,
                                            input logic [7:0] c2, input logic [7:0] c3,
                                            input logic [1:0] len);
    return {6'b0, len, c3, c2, c1, num};
  endfunction

  function automatic plan_row_t plan_row(input logic [1:0] f, input logic [39:0] d,
                                         input bit typed, input logic [2:0] en,
                                         input logic [7:0] seg);
    plan_row_t r;
    r.func = f;
    r.data = d;
    r.typed = typed;
    r.want.enable_n = en;
    r.want.segments = seg;
    return r;
  endfunction

  // Characters outside the table show blank.
  function automatic logic [6:0] char_to_glyph(input logic [7:0] c);
    logic [7:0] g;
    g = 8'h00;
    if (c >= CHAR_ZERO && c <= CHAR_LAST) begin
      g = GLYPH_ROM[c - CHAR_ZERO];
    end
    return g[6:0];
  endfunction

  // Applies one input item to the shadow state; a tick yields one scan result.
  task automatic display_step(input logic [1:0] f, input logic [39:0] d,
                              output bit produced, output result_t res);
    int v;
    int len;
    int pos;
    int i;
    logic [7:0] seg;
    produced = 1'b0;
    res = '0;
    case (f)
      FUNC_NUMBER: begin
        v = int'(d[7:0]);
        shadow_number = {8'h00, d[7:0]};
        for (i = 0; i < DIGITS; i++) begin
          shadow_digits[i] = GLYPH_ROM[v % 10][6:0];
          v = v / 10;
        end
      end
      FUNC_TEXT: begin
        len = int'(d[33:32]);
        if (len > DIGITS) len = DIGITS;
        shadow_number = TEXT_MARK;
        shadow_digits = '0;
        // The first character lands in the highest used digit.
        for (i = 0; i < len; i++) begin
          shadow_digits[len - 1 - i] = char_to_glyph(d[8 + 8 * i +: 8]);
        end
      end
      FUNC_TICK: begin
        pos = int'(shadow_scan);
        if (pos >= DIGITS) pos = 0;
        if (pos == 0) begin
          seg = {shadow_dot, shadow_digits[0]};
        end else if (pos == 1) begin
          seg = (shadow_number >= 16'd10) ? {1'b0, shadow_digits[1]} : 8'h00;
        end else begin
          seg = (shadow_number >= 16'd100) ? {1'b0, shadow_digits[2]} : 8'h00;
        end
        res.enable_n = ~(3'b001 << pos);
        res.segments = seg;
        produced = 1'b1;
        shadow_scan = 2'((pos + 1 < DIGITS) ? pos + 1 : 0);
      end
      default: ;
    endcase
  endtask

  // Offers one item until it is taken, then records what it should produce.
  task automatic push_item(input logic [1:0] f, input logic [39:0] d, input bit typed,
                           input result_t typed_res);
    bit produced;
    result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    display_step(f, d, produced, res);
    if (produced) pending_scans.push_back(typed ? typed_res : res);
  endtask

  // Register writes only happen with the block drained.
  task automatic write_dot(input logic v);
    s_tvalid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_dot = v;
  endtask

  // Mostly ticks and well-formed loads; a few unused function codes as noise.
  task automatic send_random(input int count);
    int done;
    int pick;
    logic [1:0] f;
    logic [7:0] num;
    logic [7:0] chars[3];
    int k;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      num = 8'($urandom_range(255));
      for (k = 0; k < 3; k++) begin
        chars[k] = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(CHAR_LAST, CHAR_ZERO));
      end
      if (pick < 55) begin
        f = FUNC_TICK;
      end else if (pick < 72) begin
        f = FUNC_NUMBER;
        case ($urandom_range(3))
          0: num = 8'($urandom_range(12));
          1: num = 8'($urandom_range(105, 95));
          default: ;
        endcase
      end else if (pick < 95) begin
        f = FUNC_TEXT;
      end else begin
        f = FUNC_UNUSED;
      end
      push_item(f, pack_item(num, chars[0], chars[1], chars[2], 2'($urandom_range(3))),
                1'b0, '0);
      if (f != FUNC_UNUSED) done++;
    end
  endtask

  // Receiver: random back-pressure, plus one long stall on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Every scan result is compared with the oldest pending expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_scan = m_tdata[10:0];
      if (pending_scans.size() == 0) begin
        $display("%0t: unexpected result enable_n=%b segments=%h", $time,
                 got_scan.enable_n, got_scan.segments);
        error_count++;
      end else begin
        want_scan = pending_scans.pop_front();
        if (got_scan.enable_n !== want_scan.enable_n) begin
          $display("%0t: enable_n expected %b actual %b", $time,
                   want_scan.enable_n, got_scan.enable_n);
          error_count++;
        end
        if (got_scan.segments !== want_scan.segments) begin
          $display("%0t: segments expected %h actual %h", $time,
                   want_scan.segments, got_scan.segments);
          error_count++;
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which no transfer happens anywhere.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("** seven_segment_mux_driver: FAILED **");
      $finish;
    end
  end

  initial begin
    // Directed part: typed results right after reset and for simple numbers.
    plan[0]  = plan_row(FUNC_TICK, '0, 1'b1, 3'b110, 8'h00);
    plan[1]  = plan_row(FUNC_TICK, '0, 1'b1, 3'b101, 8'h00);
    plan[2]  = plan_row(FUNC_TICK, '0, 1'b1, 3'b011, 8'h00);
    plan[3]  = plan_row(FUNC_NUMBER, pack_item(8'd255, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0,
                        3'b000, 8'h00);
    plan[4]  = plan_row(FUNC_TICK, '0, 1'b1, 3'b110, 8'h73);
    plan[5]  = plan_row(FUNC_TICK, '0, 1'b1, 3'b101, 8'h73);
    plan[6]  = plan_row(FUNC_TICK, '0, 1'b1, 3'b011, 8'h3D);
    plan[7]  = plan_row(FUNC_NUMBER, pack_item(8'd0, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0,
                        3'b000, 8'h00);
    plan[8]  = plan_row(FUNC_TICK, '0, 1'b1, 3'b110, 8'h5F);
    plan[9]  = plan_row(FUNC_NUMBER, pack_item(8'd9, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0,
                        3'b000, 8'h00);
    plan[10] = plan_row(FUNC_TICK, '0, 1'b1, 3'b101, 8'h00);
    plan[11] = plan_row(FUNC_TICK, '0, 1'b1, 3'b011, 8'h00);
    // Text at the table ends, then short text, empty text and bytes outside the table.
    plan[12] = plan_row(FUNC_TEXT, pack_item(8'h00, 8'h55, 8'h30, 8'h57, 2'd3), 1'b0,
                        3'b000, 8'h00);
    plan[13] = plan_row(FUNC_TICK, '0, 1'b0, 3'b000, 8'h00);
    plan[14] = plan_row(FUNC_TICK, '0, 1'b0, 3'b000, 8'h00);
    plan[15] = plan_row(FUNC_TICK, '0, 1'b0, 3'b000, 8'h00);
    plan[16] = plan_row(FUNC_TEXT, pack_item(8'h00, 8'hFF, 8'h00, 8'h41, 2'd2), 1'b0,
                        3'b000, 8'h00);
    plan[17] = plan_row(FUNC_TEXT, pack_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd0), 1'b0,
                        3'b000, 8'h00);
    plan[18] = plan_row(FUNC_TICK, '0, 1'b0, 3'b000, 8'h00);
    plan[19] = plan_row(FUNC_UNUSED, pack_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3), 1'b0,
                        3'b000, 8'h00);
    plan[20] = plan_row(FUNC_TICK, '0, 1'b0, 3'b000, 8'h00);
    plan[21] = plan_row(FUNC_NUMBER, pack_item(8'd100, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0,
                        3'b000, 8'h00);
    plan[22] = plan_row(FUNC_TICK, '0, 1'b0, 3'b000, 8'h00);
    plan[23] = plan_row(FUNC_NUMBER, pack_item(8'd10, 8'h00, 8'h00, 8'h00, 2'd0), 1'b0,
                        3'b000, 8'h00);
    plan[24] = plan_row(FUNC_TICK, '0, 1'b0, 3'b000, 8'h00);

    shadow_digits = '0;
    shadow_number = '0;
    shadow_scan = '0;
    shadow_dot = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 25;
    sink_idle_pct = 69;
    for (int r = 0; r < PLAN_ROWS; r++) begin
      push_item(plan[r].func, plan[r].data, plan[r].typed, plan[r].want);
    end

    write_dot(1'b1);
    send_random(135);

    src_idle_pct = 69;
    sink_idle_pct = 25;
    write_dot(1'b0);
    send_random(135);

    // No idling on either side; midway the receiver stalls for a long stretch
    // while items keep coming, so the result queue fills and input is held off.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_dot(1'b1);
    send_random(68);
    hold_req = 1'b1;
    send_random(67);

    s_tvalid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** seven_segment_mux_driver: PASSED **");
    end else begin
      $display("** seven_segment_mux_driver: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sseg_pkg.sv
src/sseg_digits.sv
src/sseg_out_queue.sv
src/seven_segment_mux_driver.sv
sim/tb_seven_segment_mux_driver.sv
